>>> hdl/bfa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared types and constants of the best-fit block allocator.
// ----------------------------------------------------------------------------
package bfa_pkg;

  localparam int DEPTH  = 64;
  localparam int ADDR_W = 27;
  localparam int PID_W  = 8;
  localparam int SIZE_W = 28;
  localparam int ST_W   = 3;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // request command codes
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [ST_W-1:0] {
    ST_OK     = 3'd0,
    ST_ZERO   = 3'd1,
    ST_NOFIT  = 3'd2,
    ST_FULL   = 3'd3,
    ST_NOPID  = 3'd4,
    ST_FROZEN = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SCAN_A,
    OP_CHECK_A,
    OP_SHR,
    OP_WA0,
    OP_WA1,
    OP_WA2,
    OP_SCAN_F,
    OP_MERGE_F,
    OP_SHL,
    OP_FINISH
  } dp_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN_A,
    S_CHECK,
    S_SHR,
    S_WA0,
    S_WA1,
    S_WA2,
    S_SCAN_F,
    S_SHL,
    S_DONE
  } ctl_state_t;

  // one table entry: range start, range last byte, owner, free flag
  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] last;
    logic [PID_W-1:0]  pid;
    logic              free;
  } ent_t;

  typedef struct packed {
    dp_op_t  op;
    status_t st;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_free;
    logic size_zero;
    logic frozen;
    logic found;
    logic scan_done;
    logic shr_done;
    logic full;
  } dp_stat_t;

endpackage

>>> hdl/bfa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfa_ctrl
// Sequencer: steps the datapath through scan, shift and table updates.
// ----------------------------------------------------------------------------
module bfa_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  bfa_pkg::dp_stat_t   stat,
  output bfa_pkg::ctl_cmd_t   cmd,
  output logic                busy
);

  bfa_pkg::ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bfa_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd.op    = bfa_pkg::OP_NONE;
    cmd.st    = bfa_pkg::ST_OK;
    busy      = (state_r != bfa_pkg::S_IDLE);
    case (state_r)
      bfa_pkg::S_IDLE: begin
        if (start) begin
          cmd.op    = bfa_pkg::OP_LOAD;
          state_nxt = bfa_pkg::S_DECODE;
        end
      end
      bfa_pkg::S_DECODE: begin
        if (!stat.is_free && stat.size_zero) begin
          cmd.op    = bfa_pkg::OP_FINISH;
          cmd.st    = bfa_pkg::ST_ZERO;
          state_nxt = bfa_pkg::S_IDLE;
        end else if (!stat.is_free) begin
          state_nxt = bfa_pkg::S_SCAN_A;
        end else if (stat.frozen) begin
          cmd.op    = bfa_pkg::OP_FINISH;
          cmd.st    = bfa_pkg::ST_FROZEN;
          state_nxt = bfa_pkg::S_IDLE;
        end else begin
          state_nxt = bfa_pkg::S_SCAN_F;
        end
      end
      bfa_pkg::S_SCAN_A: begin
        cmd.op = bfa_pkg::OP_SCAN_A;
        if (stat.scan_done) state_nxt = bfa_pkg::S_CHECK;
      end
      bfa_pkg::S_CHECK: begin
        if (!stat.found) begin
          cmd.op    = bfa_pkg::OP_FINISH;
          cmd.st    = bfa_pkg::ST_NOFIT;
          state_nxt = bfa_pkg::S_IDLE;
        end else if (stat.full) begin
          cmd.op    = bfa_pkg::OP_FINISH;
          cmd.st    = bfa_pkg::ST_FULL;
          state_nxt = bfa_pkg::S_IDLE;
        end else begin
          cmd.op    = bfa_pkg::OP_CHECK_A;
          state_nxt = bfa_pkg::S_SHR;
        end
      end
      bfa_pkg::S_SHR: begin
        cmd.op = bfa_pkg::OP_SHR;
        if (stat.shr_done) state_nxt = bfa_pkg::S_WA0;
      end
      bfa_pkg::S_WA0: begin
        cmd.op    = bfa_pkg::OP_WA0;
        state_nxt = bfa_pkg::S_WA1;
      end
      bfa_pkg::S_WA1: begin
        cmd.op    = bfa_pkg::OP_WA1;
        state_nxt = bfa_pkg::S_WA2;
      end
      bfa_pkg::S_WA2: begin
        cmd.op    = bfa_pkg::OP_WA2;
        state_nxt = bfa_pkg::S_DONE;
      end
      bfa_pkg::S_SCAN_F: begin
        if (stat.found) begin
          // read data now holds the entry after the match
          cmd.op    = bfa_pkg::OP_MERGE_F;
          state_nxt = bfa_pkg::S_SHL;
        end else if (stat.scan_done) begin
          cmd.op    = bfa_pkg::OP_FINISH;
          cmd.st    = bfa_pkg::ST_NOPID;
          state_nxt = bfa_pkg::S_IDLE;
        end else begin
          cmd.op = bfa_pkg::OP_SCAN_F;
        end
      end
      bfa_pkg::S_SHL: begin
        cmd.op = bfa_pkg::OP_SHL;
        if (stat.scan_done) state_nxt = bfa_pkg::S_DONE;
      end
      bfa_pkg::S_DONE: begin
        cmd.op    = bfa_pkg::OP_FINISH;
        cmd.st    = bfa_pkg::ST_OK;
        state_nxt = bfa_pkg::S_IDLE;
      end
      default: begin
        state_nxt = bfa_pkg::S_IDLE;
      end
    endcase
  end

endmodule

>>> hdl/bfa_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfa_dp
// Datapath: block table memory, scan compare, shift engine, result register.
// ----------------------------------------------------------------------------
module bfa_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  bfa_pkg::ctl_cmd_t               cmd,
  output bfa_pkg::dp_stat_t               stat,
  input  logic                            in_command,
  input  logic [bfa_pkg::PID_W-1:0]       in_pid,
  input  logic [bfa_pkg::SIZE_W-1:0]      in_size,
  input  logic                            cfg_wr_en,
  input  logic                            cfg_wr_data,
  output logic                            out_valid,
  output logic [bfa_pkg::ST_W-1:0]        out_status,
  output logic [bfa_pkg::ADDR_W-1:0]      out_address
);

  localparam int AW = bfa_pkg::ADDR_W;
  localparam int IW = bfa_pkg::IDX_W;
  localparam int CW = bfa_pkg::CNT_W;
  localparam int SW = bfa_pkg::SIZE_W;

  localparam bfa_pkg::ent_t RST_ENT = '{start: '0, last: '1, pid: '0, free: 1'b1};

  bfa_pkg::ent_t mem [bfa_pkg::DEPTH];

  logic                  is_free_r, is_free_nxt;
  logic [bfa_pkg::PID_W-1:0] pid_r, pid_nxt;
  logic [SW-1:0]         size_r, size_nxt;
  logic                  freeze_r;
  logic [CW-1:0]         count_r, count_nxt;
  logic [CW-1:0]         ptr_r, ptr_nxt;
  logic                  rvalid_r, rvalid_nxt;
  logic [IW-1:0]         ridx_r;
  bfa_pkg::ent_t         rdata_r;
  logic                  init_r;
  logic                  found_r, found_nxt;
  logic [IW-1:0]         best_idx_r, best_idx_nxt;
  logic [AW-1:0]         best_start_r, best_start_nxt;
  logic [AW-1:0]         best_last_r, best_last_nxt;
  logic [SW-1:0]         best_use_r, best_use_nxt;
  bfa_pkg::ent_t         prev_r, prev_nxt;
  logic [1:0]            k_r, k_nxt;
  logic                  ovalid_r, ovalid_nxt;
  logic [bfa_pkg::ST_W-1:0] status_r, status_nxt;
  logic [AW-1:0]         addr_r, addr_nxt;

  logic                  rd_en, we;
  logic [IW-1:0]         ra, wa;
  bfa_pkg::ent_t         wd;

  // scan evaluation of the entry in the read register
  logic [SW-1:0] ev_a, ev_use;
  // split of the chosen range
  logic [SW-1:0] al_w, nend_w;
  logic [AW-1:0] al, nend;
  logic          pre, tail;
  logic [1:0]    need;
  logic          prevfree, nextfree;
  logic [IW-1:0] mwa;

  always_comb begin
    ev_a   = ({1'b0, rdata_r.start} + SW'(3)) & ~SW'(3);
    ev_use = {1'b0, rdata_r.last} - ev_a + SW'(1);
    al_w   = ({1'b0, best_start_r} + SW'(3)) & ~SW'(3);
    al     = al_w[AW-1:0];
    nend_w = {1'b0, al} + size_r - SW'(1);
    nend   = nend_w[AW-1:0];
    pre    = (al != best_start_r);
    tail   = (nend < best_last_r);
    need   = {1'b0, pre} + {1'b0, tail};
    prevfree = (best_idx_r != '0) && prev_r.free;
    nextfree = rvalid_r && rdata_r.free;
    mwa      = prevfree ? best_idx_r - IW'(1) : best_idx_r;
  end

  always_comb begin
    stat.is_free   = is_free_r;
    stat.size_zero = (size_r == '0);
    stat.frozen    = freeze_r;
    stat.found     = found_r;
    stat.scan_done = (ptr_r >= count_r) && !rvalid_r;
    stat.shr_done  = !(ptr_r > {1'b0, best_idx_r}) && !rvalid_r;
    stat.full      = ({1'b0, count_r} + {{(CW-1){1'b0}}, need})
                     > (CW+1)'(bfa_pkg::DEPTH);
  end

  always_comb begin
    is_free_nxt    = is_free_r;
    pid_nxt        = pid_r;
    size_nxt       = size_r;
    count_nxt      = count_r;
    ptr_nxt        = ptr_r;
    rvalid_nxt     = 1'b0;
    found_nxt      = found_r;
    best_idx_nxt   = best_idx_r;
    best_start_nxt = best_start_r;
    best_last_nxt  = best_last_r;
    best_use_nxt   = best_use_r;
    prev_nxt       = prev_r;
    k_nxt          = k_r;
    ovalid_nxt     = 1'b0;
    status_nxt     = status_r;
    addr_nxt       = addr_r;
    rd_en          = 1'b0;
    ra             = ptr_r[IW-1:0];
    we             = 1'b0;
    wa             = best_idx_r;
    wd             = rdata_r;
    case (cmd.op)
      bfa_pkg::OP_LOAD: begin
        is_free_nxt = (in_command == bfa_pkg::CMD_FREE);
        pid_nxt     = in_pid;
        size_nxt    = in_size;
        ptr_nxt     = '0;
        found_nxt   = 1'b0;
      end
      bfa_pkg::OP_SCAN_A: begin
        rd_en = (ptr_r < count_r);
        if (rd_en) ptr_nxt = ptr_r + CW'(1);
        if (rvalid_r && rdata_r.free && !(ev_a > {1'b0, rdata_r.last}) &&
            ev_use >= size_r && (!found_r || ev_use < best_use_r)) begin
          found_nxt      = 1'b1;
          best_idx_nxt   = ridx_r;
          best_start_nxt = rdata_r.start;
          best_last_nxt  = rdata_r.last;
          best_use_nxt   = ev_use;
        end
      end
      bfa_pkg::OP_CHECK_A: begin
        ptr_nxt = count_r - CW'(1);
      end
      bfa_pkg::OP_SHR: begin
        // move entries above the chosen one up by the number of splits
        rd_en = (ptr_r > {1'b0, best_idx_r});
        if (rd_en) ptr_nxt = ptr_r - CW'(1);
        if (rvalid_r) begin
          we = 1'b1;
          wa = ridx_r + IW'(need);
        end
      end
      bfa_pkg::OP_WA0: begin
        we = 1'b1;
        wa = best_idx_r;
        if (pre) wd = '{start: best_start_r, last: al - AW'(1), pid: '0, free: 1'b1};
        else     wd = '{start: al, last: nend, pid: pid_r, free: 1'b0};
      end
      bfa_pkg::OP_WA1: begin
        we = pre || tail;
        wa = best_idx_r + IW'(1);
        if (pre) wd = '{start: al, last: nend, pid: pid_r, free: 1'b0};
        else     wd = '{start: nend + AW'(1), last: best_last_r, pid: '0, free: 1'b1};
      end
      bfa_pkg::OP_WA2: begin
        we = pre && tail;
        wa = best_idx_r + IW'(2);
        wd = '{start: nend + AW'(1), last: best_last_r, pid: '0, free: 1'b1};
      end
      bfa_pkg::OP_SCAN_F: begin
        rd_en = (ptr_r < count_r) && !found_r;
        if (rd_en) ptr_nxt = ptr_r + CW'(1);
        if (rvalid_r && !found_r) begin
          if (!rdata_r.free && rdata_r.pid == pid_r) begin
            found_nxt      = 1'b1;
            best_idx_nxt   = ridx_r;
            best_start_nxt = rdata_r.start;
            best_last_nxt  = rdata_r.last;
          end else begin
            prev_nxt = rdata_r;
          end
        end
      end
      bfa_pkg::OP_MERGE_F: begin
        we = 1'b1;
        wa = mwa;
        wd = '{start: prevfree ? prev_r.start : best_start_r,
               last:  nextfree ? rdata_r.last : best_last_r,
               pid: '0, free: 1'b1};
        k_nxt   = {1'b0, prevfree} + {1'b0, nextfree};
        ptr_nxt = {1'b0, mwa} + CW'(1) + CW'({1'b0, prevfree} + {1'b0, nextfree});
      end
      bfa_pkg::OP_SHL: begin
        rd_en = (ptr_r < count_r);
        if (rd_en) ptr_nxt = ptr_r + CW'(1);
        if (rvalid_r) begin
          we = 1'b1;
          wa = ridx_r - IW'(k_r);
        end
      end
      bfa_pkg::OP_FINISH: begin
        ovalid_nxt = 1'b1;
        status_nxt = cmd.st;
        addr_nxt   = (cmd.st == bfa_pkg::ST_OK && !is_free_r) ? al : '0;
        if (cmd.st == bfa_pkg::ST_OK) begin
          count_nxt = is_free_r ? count_r - CW'(k_r) : count_r + CW'(need);
        end
      end
      default: begin
      end
    endcase
    rvalid_nxt = rd_en;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= CW'(1);
      freeze_r <= 1'b0;
      rvalid_r <= 1'b0;
      init_r   <= 1'b1;
      found_r  <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      if (cfg_wr_en) freeze_r <= cfg_wr_data;
      rvalid_r <= rvalid_nxt;
      if (we && wa == '0) init_r <= 1'b0;
      found_r  <= found_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    is_free_r    <= is_free_nxt;
    pid_r        <= pid_nxt;
    size_r       <= size_nxt;
    ptr_r        <= ptr_nxt;
    best_idx_r   <= best_idx_nxt;
    best_start_r <= best_start_nxt;
    best_last_r  <= best_last_nxt;
    best_use_r   <= best_use_nxt;
    prev_r       <= prev_nxt;
    k_r          <= k_nxt;
    status_r     <= status_nxt;
    addr_r       <= addr_nxt;
  end

  // table memory: one read, one write per cycle, registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= (init_r && ra == '0) ? RST_ENT : mem[ra];
      ridx_r  <= ra;
    end
    if (we) mem[wa] <= wd;
  end

  assign out_valid   = ovalid_r;
  assign out_status  = status_r;
  assign out_address = addr_r;

endmodule

>>> hdl/best_fit_block_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// best_fit_block_allocator_core
// Best-fit allocator over an ordered table of address ranges with coalescing.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; exactly one result
// follows as a one-cycle pulse on out_valid with out_status and out_address,
// and the receiver cannot stall it. One request runs at a time. The block
// table sits in a memory with one read and one write port, read one entry per
// cycle: an allocate scans all N table entries and then shifts those above
// the best fit, and a free scans up to the match and shifts the rest, where N
// is the current number of table entries.
// ----------------------------------------------------------------------------
module best_fit_block_allocator_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic                            in_command,
  input  logic [bfa_pkg::PID_W-1:0]       in_pid,
  input  logic [bfa_pkg::SIZE_W-1:0]      in_size,
  input  logic                            cfg_wr_en,
  input  logic                            cfg_wr_data,
  output logic                            out_valid,
  output logic [bfa_pkg::ST_W-1:0]        out_status,
  output logic [bfa_pkg::ADDR_W-1:0]      out_address
);

  bfa_pkg::ctl_cmd_t cmd;
  bfa_pkg::dp_stat_t stat;

  bfa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  bfa_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_command  (in_command),
    .in_pid      (in_pid),
    .in_size     (in_size),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_valid   (out_valid),
    .out_status  (out_status),
    .out_address (out_address)
  );

endmodule
